// File: rtl/core/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// Needs clk and rst (synchronous, active high) in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ZSWD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ZSWD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/zswd_pkg.sv
// Shared types and constants for the zero-suppressed waveform decoder.
// No dependencies; imported by front, back and top level.
package zswd_pkg;

  localparam logic [2:0] KIND_SIZE    = 3'd0;
  localparam logic [2:0] KIND_TAG     = 3'd1;
  localparam logic [2:0] KIND_PED     = 3'd2;
  localparam logic [2:0] KIND_SAMPLES = 3'd3;
  localparam logic [2:0] KIND_FILL    = 3'd4;
  localparam logic [2:0] KIND_IGNORED = 3'd5;

  localparam logic [1:0] EV_NONE      = 2'd0;
  localparam logic [1:0] EV_BEGIN     = 2'd1;
  localparam logic [1:0] EV_END       = 2'd2;
  localparam logic [1:0] EV_BEGIN_END = 2'd3;

  localparam logic [1:0] STOP_OK      = 2'd0;
  localparam logic [1:0] STOP_OVERRUN = 2'd1;
  localparam logic [1:0] STOP_BADCODE = 2'd2;

  localparam logic [1:0] CODE_FILL    = 2'd0;
  localparam logic [1:0] CODE_SAMPLES = 2'd3;

  localparam logic [23:0] RECORD_SAMPLES_RESET = 24'd1024;
  localparam logic [31:0] MIN_RECORD_WORDS     = 32'd3;
  localparam logic [24:0] SAMPLE_MAX           = 25'h1FF_FFFF;
  localparam logic [23:0] PULSE_MAX            = 24'hFF_FFFF;
  localparam logic [25:0] LENGTH_SLACK         = 26'd16;
  localparam logic [25:0] SAMPLES_PER_WORD     = 26'd3;

  typedef enum logic [1:0] {
    CLS_SIZE,
    CLS_TAG,
    CLS_PED,
    CLS_DATA
  } word_class_t;

  typedef struct packed {
    word_class_t cls;
    logic        last;
    logic [31:0] word;
  } mid_entry_t;

  typedef struct packed {
    logic [2:0]  word_kind;
    logic [9:0]  sample_a;
    logic [9:0]  sample_b;
    logic [9:0]  sample_c;
    logic [24:0] samples_so_far;
    logic [23:0] fill_count;
    logic [39:0] header_value;
    logic [1:0]  pulse_event;
    logic [23:0] pulse_count;
    logic [1:0]  stop_status;
    logic        length_warning;
    logic        record_end;
  } result_t;

endpackage

// File: rtl/core/zswd_fifo.sv
// Small register-based FIFO, used for the classified-word queue and the result queue.
// Generic; no package dependency. DEPTH must be at least 2.
module zswd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// File: rtl/core/zswd_front.sv
// Front end: tracks the position of each word in its record and tags it.
// Depends on zswd_pkg (word_class_t, mid_entry_t).
module zswd_front
  import zswd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [31:0] data_word,
  output mid_entry_t  entry
);

  logic [31:0] word_position;
  logic [31:0] record_words;
  logic        last;

  // word_position never reaches all-ones, so the +1 cannot wrap
  assign last = (word_position != '0) && ((word_position + 32'd1) >= record_words);

  always_comb begin
    entry.word = data_word;
    entry.last = last;
    if (word_position == 32'd0) begin
      entry.cls = CLS_SIZE;
    end else if (word_position == 32'd1) begin
      entry.cls = CLS_TAG;
    end else if (word_position == 32'd2) begin
      entry.cls = CLS_PED;
    end else begin
      entry.cls = CLS_DATA;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_position <= '0;
      record_words  <= '0;
    end else if (accept) begin
      if (word_position == 32'd0) begin
        record_words <= (data_word < MIN_RECORD_WORDS) ? MIN_RECORD_WORDS : data_word;
      end
      word_position <= last ? 32'd0 : word_position + 32'd1;
    end
  end

endmodule

// File: rtl/core/zswd_back.sv
// Back end: decodes tagged words, keeps sample/pulse/pedestal state, builds results.
// Depends on zswd_pkg (mid_entry_t, result_t, code constants).
module zswd_back
  import zswd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [23:0] cfg_data,
  input  logic        step,
  input  mid_entry_t  entry,
  output result_t     result
);

  logic [23:0] record_samples;
  logic [24:0] sample_total;
  logic [39:0] pedestal_level;
  logic        in_baseline;
  logic        decode_stopped;
  logic [23:0] pulses_opened;

  logic [24:0] sample_total_next;
  logic [39:0] pedestal_level_next;
  logic        in_baseline_next;
  logic        decode_stopped_next;
  logic [23:0] pulses_opened_next;

  logic [39:0] ped_word;
  logic [2:0]  ped_shift;
  logic [34:0] fill_n;
  logic [34:0] fill_sum;
  logic [25:0] three_sum;
  logic        began;

  assign ped_shift = 3'd7 - entry.word[30:28];
  assign ped_word  = entry.word[31] ? ({25'd0, entry.word[14:0]} << ped_shift)
                                    : {entry.word[30:0], 9'd0};
  assign fill_n    = {entry.word, 3'd0};
  assign fill_sum  = fill_n + {10'd0, sample_total};
  assign three_sum = {1'b0, sample_total} + SAMPLES_PER_WORD;

  always_comb begin
    result              = '0;
    result.word_kind    = KIND_IGNORED;
    sample_total_next   = sample_total;
    pedestal_level_next = pedestal_level;
    in_baseline_next    = in_baseline;
    decode_stopped_next = decode_stopped;
    pulses_opened_next  = pulses_opened;
    began               = 1'b0;

    unique case (entry.cls)
      CLS_SIZE: begin
        result.word_kind = KIND_SIZE;
      end
      CLS_TAG: begin
        result.word_kind    = KIND_TAG;
        result.header_value = {8'd0, entry.word};
      end
      CLS_PED: begin
        result.word_kind    = KIND_PED;
        result.header_value = ped_word;
        pedestal_level_next = ped_word;
      end
      CLS_DATA: begin
        if (!decode_stopped) begin
          case (entry.word[31:30])
            CODE_SAMPLES: begin
              result.word_kind = KIND_SAMPLES;
              result.sample_a  = entry.word[9:0];
              result.sample_b  = entry.word[19:10];
              result.sample_c  = entry.word[29:20];
              if (in_baseline) begin
                if (pulses_opened != PULSE_MAX) begin
                  pulses_opened_next = pulses_opened + 24'd1;
                end
                began              = 1'b1;
                result.pulse_event = EV_BEGIN;
              end
              in_baseline_next  = 1'b0;
              sample_total_next = (three_sum > {1'b0, SAMPLE_MAX}) ? SAMPLE_MAX
                                                                   : three_sum[24:0];
            end
            CODE_FILL: begin
              if (fill_sum > {11'd0, record_samples}) begin
                decode_stopped_next = 1'b1;
                result.stop_status  = STOP_OVERRUN;
              end else begin
                // sum fits under record_samples, so no saturation here
                result.word_kind    = KIND_FILL;
                result.fill_count   = fill_n[23:0];
                result.header_value = pedestal_level;
                sample_total_next   = fill_sum[24:0];
                if (!in_baseline) begin
                  result.pulse_event = EV_END;
                end
                in_baseline_next = 1'b1;
              end
            end
            default: begin
              decode_stopped_next = 1'b1;
              result.stop_status  = STOP_BADCODE;
            end
          endcase
        end
      end
      default: begin
        result.word_kind = KIND_IGNORED;
      end
    endcase

    result.samples_so_far = sample_total_next;
    result.pulse_count    = pulses_opened_next;
    result.record_end     = entry.last;

    if (entry.last) begin
      if (!in_baseline_next) begin
        result.pulse_event = began ? EV_BEGIN_END : EV_END;
      end
      result.length_warning = ({1'b0, sample_total_next} >
                               ({2'd0, record_samples} + LENGTH_SLACK));
      sample_total_next   = '0;
      in_baseline_next    = 1'b1;
      decode_stopped_next = 1'b0;
      pulses_opened_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_samples <= RECORD_SAMPLES_RESET;
      sample_total   <= '0;
      pedestal_level <= '0;
      in_baseline    <= 1'b1;
      decode_stopped <= 1'b0;
      pulses_opened  <= '0;
    end else begin
      if (cfg_write) begin
        record_samples <= cfg_data;
      end
      if (step) begin
        sample_total   <= sample_total_next;
        pedestal_level <= pedestal_level_next;
        in_baseline    <= in_baseline_next;
        decode_stopped <= decode_stopped_next;
        pulses_opened  <= pulses_opened_next;
      end
    end
  end

endmodule

// File: rtl/core/zero_suppressed_waveform_decoder.sv
// Top level of the zero-suppressed waveform decoder: front, word queue, back, result queue.
// Depends on zswd_pkg, zswd_fifo, zswd_front, zswd_back and assert_macros.svh.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  input    | push / full          | data_word
//  result   | pop / empty          | word_kind .. record_end (one port per field)
//  config   | cfg_valid/cfg_ready  | cfg_data (record_samples)
//
// One result per input word; one word per cycle while the result side keeps up.
// The front tags words into the word queue, the back decodes them into the result queue.
// cfg_ready is always high. Synchronous reset empties both queues and restores
// the record state; record_samples returns to 1024. A stalled result side fills
// the result queue, then the word queue, and only then raises full.
`include "assert_macros.svh"

module zero_suppressed_waveform_decoder
  import zswd_pkg::*;
#(
  parameter int MID_DEPTH = 2,
  parameter int OUT_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] data_word,
  input  logic        pop,
  output logic        empty,
  output logic [2:0]  word_kind,
  output logic [9:0]  sample_a,
  output logic [9:0]  sample_b,
  output logic [9:0]  sample_c,
  output logic [24:0] samples_so_far,
  output logic [23:0] fill_count,
  output logic [39:0] header_value,
  output logic [1:0]  pulse_event,
  output logic [23:0] pulse_count,
  output logic [1:0]  stop_status,
  output logic        length_warning,
  output logic        record_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data
);

  mid_entry_t front_entry;
  mid_entry_t back_entry;
  result_t    back_result;
  result_t    out_result;
  logic       in_accept;
  logic       mid_empty;
  logic       out_full;
  logic       back_step;

  assign cfg_ready = 1'b1;
  assign in_accept = push && !full;
  assign back_step = !mid_empty && !out_full;

  zswd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .data_word (data_word),
    .entry     (front_entry)
  );

  zswd_fifo #(
    .WIDTH ($bits(mid_entry_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (in_accept),
    .wdata (front_entry),
    .full  (full),
    .pop   (back_step),
    .rdata (back_entry),
    .empty (mid_empty)
  );

  zswd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .step      (back_step),
    .entry     (back_entry),
    .result    (back_result)
  );

  zswd_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (back_step),
    .wdata (back_result),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_result),
    .empty (empty)
  );

  assign word_kind      = out_result.word_kind;
  assign sample_a       = out_result.sample_a;
  assign sample_b       = out_result.sample_b;
  assign sample_c       = out_result.sample_c;
  assign samples_so_far = out_result.samples_so_far;
  assign fill_count     = out_result.fill_count;
  assign header_value   = out_result.header_value;
  assign pulse_event    = out_result.pulse_event;
  assign pulse_count    = out_result.pulse_count;
  assign stop_status    = out_result.stop_status;
  assign length_warning = out_result.length_warning;
  assign record_end     = out_result.record_end;

  // a pulse can only open on a sample word
  `ZSWD_ASSERT_NOW(a_begin_on_samples, !empty && (pulse_event == EV_BEGIN || pulse_event == EV_BEGIN_END), word_kind == KIND_SAMPLES, "pulse opened on a non-sample word")
  // the stopping word itself is reported as ignored
  `ZSWD_ASSERT_NOW(a_stop_is_ignored, !empty && stop_status != STOP_OK, word_kind == KIND_IGNORED, "stop status on a decoded word")
  // length check happens only at record end
  `ZSWD_ASSERT_NOW(a_warn_at_end, !empty && length_warning, record_end, "length warning away from record end")
  // fill count only on a baseline fill beat
  `ZSWD_ASSERT_NOW(a_fill_kind, !empty && fill_count != '0, word_kind == KIND_FILL, "fill count on a non-fill word")
  // back never drops a beat: a tagged word waiting with room downstream is taken
  `ZSWD_ASSERT_NEXT(a_back_moves, !mid_empty && !out_full && !push && empty, !empty, "back end stalled with room in result queue")

endmodule
